>>> src/spd_pkg.sv
package spd_pkg;

   // packet geometry
   localparam int PKT_LEN = 14;
   localparam int POS_W   = $clog2(PKT_LEN + 1);

   // framing and digit characters
   localparam logic [7:0] ASCII_ZERO = 8'h30;
   localparam logic [7:0] ASCII_NINE = 8'h39;
   localparam logic [7:0] CHAR_CR    = 8'h0d;
   localparam logic [7:0] CHAR_LF    = 8'h0a;

   // function byte codes (byte 6)
   localparam logic [7:0] FN_AMP0  = 8'h30;
   localparam logic [7:0] FN_DIODE = 8'h31;
   localparam logic [7:0] FN_HZ    = 8'h32;
   localparam logic [7:0] FN_OHM   = 8'h33;
   localparam logic [7:0] FN_COND  = 8'h35;
   localparam logic [7:0] FN_FARAD = 8'h36;
   localparam logic [7:0] FN_VOLT  = 8'h3B;
   localparam logic [7:0] FN_UA    = 8'h3D;
   localparam logic [7:0] FN_MA    = 8'h3F;

   // measurement modes
   localparam logic [3:0] MODE_INVALID = 4'd0;
   localparam logic [3:0] MODE_VOLT    = 4'd1;
   localparam logic [3:0] MODE_AMP     = 4'd2;
   localparam logic [3:0] MODE_OHM     = 4'd3;
   localparam logic [3:0] MODE_DIODE   = 4'd4;
   localparam logic [3:0] MODE_HZ      = 4'd5;
   localparam logic [3:0] MODE_FARAD   = 4'd6;
   localparam logic [3:0] MODE_COND    = 4'd7;
   localparam logic [3:0] MODE_DUTY    = 4'd8;

   // kind codes
   localparam logic [1:0] POWER_NONE = 2'd1;
   localparam logic [1:0] POWER_AC   = 2'd2;
   localparam logic [1:0] POWER_DC   = 2'd3;
   localparam logic [1:0] ERR_NONE   = 2'd1;
   localparam logic [1:0] ERR_OVER   = 2'd2;
   localparam logic [1:0] ERR_UNDER  = 2'd3;
   localparam logic [1:0] PEAK_NONE  = 2'd1;
   localparam logic [1:0] PEAK_MAX   = 2'd2;
   localparam logic [1:0] PEAK_MIN   = 2'd3;

   typedef struct packed {
      logic [PKT_LEN-1:0][7:0] pkt_bytes;
      logic                    complete;   // all fourteen bytes present
   } packet_type;

   typedef struct packed {
      logic               packet_ok;
      logic signed [17:0] mantissa;
      logic signed [4:0]  exponent;
      logic [3:0]         mode;
      logic [1:0]         power_kind;
      logic [1:0]         range_error;
      logic [1:0]         peak_kind;
      logic               battery_low;
      logic               relative_on;
      logic               hold_on;
      logic               auto_range;
   } result_type;

   // range tables; amps has three, diode and conductance none
   typedef enum logic [3:0] {
      TAB_NONE, TAB_DUTY, TAB_HZ, TAB_AMP0, TAB_OHM,
      TAB_FARAD, TAB_VOLT, TAB_UA, TAB_MA
   } exp_tab_type;

   typedef struct packed {
      logic              ok;
      logic signed [4:0] value;
   } exp_type;

   function automatic exp_type range_exp(exp_tab_type tab, logic [7:0] code);
      logic [7:0]        idx;
      logic signed [4:0] sidx;
      exp_type           r;
      idx    = code - ASCII_ZERO;
      sidx   = $signed(idx[4:0]);
      r.ok    = 1'b0;
      r.value = '0;
      if (tab == TAB_NONE) begin
         r.ok = 1'b1;
      end else if (code >= ASCII_ZERO) begin
         unique case (tab)
            TAB_DUTY: begin
               r.ok = (idx == 8'd0);  r.value = -5'sd1;
            end
            TAB_HZ: begin
               // index two is a hole in the table
               r.ok    = (idx < 8'd8) && (idx != 8'd2);
               r.value = (idx < 8'd2) ? sidx - 5'sd2 : sidx - 5'sd3;
            end
            TAB_AMP0: begin
               r.ok = (idx == 8'd0);  r.value = -5'sd3;
            end
            TAB_OHM: begin
               r.ok = (idx < 8'd7);  r.value = sidx - 5'sd2;
            end
            TAB_FARAD: begin
               r.ok = (idx < 8'd8);  r.value = sidx - 5'sd12;
            end
            TAB_VOLT: begin
               r.ok    = (idx < 8'd5);
               r.value = (idx == 8'd4) ? -5'sd5 : sidx - 5'sd4;
            end
            TAB_UA: begin
               r.ok = (idx < 8'd2);  r.value = sidx - 5'sd8;
            end
            TAB_MA: begin
               r.ok = (idx < 8'd2);  r.value = sidx - 5'sd6;
            end
            default: begin
               r.ok = 1'b0;  r.value = '0;
            end
         endcase
      end
      return r;
   endfunction

endpackage

>>> src/spd_front.sv
module spd_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   output logic                full,
   input  logic [7:0]          req_rx_byte,
   input  logic                req_last_byte,
   input  logic                fifo_full,
   output logic                fifo_push,
   output spd_pkg::packet_type fifo_pkt
);
   import spd_pkg::*;

   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [7:0]         store_ff [PKT_LEN];
   logic               accept;

   assign full      = fifo_full;
   assign accept    = push && !fifo_full;
   assign fifo_push = accept && req_last_byte;

   // merge the word arriving now into the captured packet
   always_comb begin
      for (int i = 0; i < PKT_LEN; i++) begin
         fifo_pkt.pkt_bytes[i] = (pos_ff == POS_W'(i)) ? req_rx_byte : store_ff[i];
      end
      fifo_pkt.complete = (pos_ff >= POS_W'(PKT_LEN - 1));
   end

   always_comb begin
      pos_in = pos_ff;
      if (accept) begin
         if (req_last_byte) begin
            pos_in = '0;
         end else if (pos_ff < POS_W'(PKT_LEN)) begin
            pos_in = pos_ff + POS_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else begin
         pos_ff <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && pos_ff < POS_W'(PKT_LEN)) begin
         store_ff[pos_ff] <= req_rx_byte;
      end
   end

   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= POS_W'(PKT_LEN))
      else $error("byte position past packet length");

endmodule

>>> src/spd_pkt_fifo.sv
module spd_pkt_fifo (
   input  logic                clock,
   input  logic                reset,
   input  logic                wr_push,
   input  spd_pkg::packet_type wr_pkt,
   output logic                wr_full,
   input  logic                rd_pop,
   output spd_pkg::packet_type rd_pkt,
   output logic                rd_empty
);
   import spd_pkg::*;

   packet_type  mem_ff [2];
   logic        wr_ptr_ff, rd_ptr_ff;
   logic [1:0]  cnt_ff, cnt_in;
   logic        do_push, do_pop;

   assign wr_full  = (cnt_ff == 2'd2);
   assign rd_empty = (cnt_ff == 2'd0);
   assign rd_pkt   = mem_ff[rd_ptr_ff];
   assign do_push  = wr_push && !wr_full;
   assign do_pop   = rd_pop && !rd_empty;

   always_comb begin
      cnt_in = cnt_ff;
      if (do_push && !do_pop) cnt_in = cnt_ff + 2'd1;
      if (!do_push && do_pop) cnt_in = cnt_ff - 2'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= '0;
      end else begin
         if (do_push) wr_ptr_ff <= !wr_ptr_ff;
         if (do_pop)  rd_ptr_ff <= !rd_ptr_ff;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wr_ptr_ff] <= wr_pkt;
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      wr_push |-> !wr_full)
      else $error("packet pushed into full queue");

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff != 2'd3)
      else $error("packet queue count out of range");

endmodule

>>> src/spd_back.sv
module spd_back (
   input  logic                clock,
   input  logic                reset,
   input  spd_pkg::packet_type pkt,
   input  logic                pkt_empty,
   output logic                pkt_pop,
   output logic                empty,
   input  logic                pop,
   output spd_pkg::result_type rsp
);
   import spd_pkg::*;

   result_type  held_ff, held_in;
   result_type  oq_ff [2];
   logic        oq_wr_ff, oq_rd_ff;
   logic [1:0]  oq_cnt_ff, oq_cnt_in;
   logic        oq_push, oq_pop;

   logic [PKT_LEN-1:0][7:0] p;
   logic               hdr_ok, digits_ok, fn_ok, decode_ok;
   logic [3:0]         dig [5];
   logic [16:0]        magnitude;
   logic signed [17:0] mant;
   logic [3:0]         mode;
   exp_tab_type        tab;
   exp_type            ex;
   result_type         entry;

   assign p = pkt.pkt_bytes;

   always_comb begin
      hdr_ok    = (p[0][5:4] == 2'b11) && (p[12] == CHAR_CR) && (p[13] == CHAR_LF);
      digits_ok = 1'b1;
      for (int i = 0; i < 5; i++) begin
         digits_ok = digits_ok && (p[i+1] >= ASCII_ZERO) && (p[i+1] <= ASCII_NINE);
         dig[i]    = p[i+1][3:0];
      end
      magnitude = 17'(dig[0]) * 17'd10000 + 17'(dig[1]) * 17'd1000
                + 17'(dig[2]) * 17'd100 + 17'(dig[3]) * 17'd10 + 17'(dig[4]);
      mant = p[7][2] ? -$signed({1'b0, magnitude}) : $signed({1'b0, magnitude});
   end

   // mode: duty flag, then frequency flag, then function byte
   always_comb begin
      fn_ok = 1'b1;
      mode  = MODE_INVALID;
      tab   = TAB_NONE;
      if (p[7][3]) begin
         mode = MODE_DUTY;  tab = TAB_DUTY;
      end else if (p[10][0]) begin
         mode = MODE_HZ;    tab = TAB_HZ;
      end else begin
         unique case (p[6])
            FN_AMP0:  begin mode = MODE_AMP;   tab = TAB_AMP0;  end
            FN_DIODE: begin mode = MODE_DIODE; tab = TAB_NONE;  end
            FN_HZ:    begin mode = MODE_HZ;    tab = TAB_HZ;    end
            FN_OHM:   begin mode = MODE_OHM;   tab = TAB_OHM;   end
            FN_COND:  begin mode = MODE_COND;  tab = TAB_NONE;  end
            FN_FARAD: begin mode = MODE_FARAD; tab = TAB_FARAD; end
            FN_VOLT:  begin mode = MODE_VOLT;  tab = TAB_VOLT;  end
            FN_UA:    begin mode = MODE_AMP;   tab = TAB_UA;    end
            FN_MA:    begin mode = MODE_AMP;   tab = TAB_MA;    end
            default:  begin fn_ok = 1'b0; end
         endcase
      end
      ex = range_exp(tab, p[0]);
      decode_ok = pkt.complete && hdr_ok && digits_ok && fn_ok && ex.ok;
   end

   always_comb begin
      entry = held_ff;
      if (decode_ok) begin
         entry.mantissa    = mant;
         entry.exponent    = ex.value;
         entry.mode        = mode;
         entry.power_kind  = p[10][3] ? POWER_DC : (p[10][2] ? POWER_AC : POWER_NONE);
         entry.range_error = p[7][0]  ? ERR_OVER : (p[9][3]  ? ERR_UNDER : ERR_NONE);
         entry.peak_kind   = p[9][2]  ? PEAK_MAX : (p[9][1]  ? PEAK_MIN : PEAK_NONE);
         entry.battery_low = p[7][1];
         entry.relative_on = p[8][1];
         entry.hold_on     = p[11][1];
         entry.auto_range  = p[10][1];
      end
      entry.packet_ok = decode_ok;
   end

   assign oq_push = !pkt_empty && (oq_cnt_ff != 2'd2);
   assign pkt_pop = oq_push;
   assign empty   = (oq_cnt_ff == 2'd0);
   assign oq_pop  = pop && !empty;
   assign rsp     = oq_ff[oq_rd_ff];

   always_comb begin
      held_in = held_ff;
      if (oq_push && decode_ok) held_in = entry;
      oq_cnt_in = oq_cnt_ff;
      if (oq_push && !oq_pop) oq_cnt_in = oq_cnt_ff + 2'd1;
      if (!oq_push && oq_pop) oq_cnt_in = oq_cnt_ff - 2'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff   <= '0;
         oq_wr_ff  <= 1'b0;
         oq_rd_ff  <= 1'b0;
         oq_cnt_ff <= '0;
      end else begin
         held_ff   <= held_in;
         oq_cnt_ff <= oq_cnt_in;
         if (oq_push) oq_wr_ff <= !oq_wr_ff;
         if (oq_pop)  oq_rd_ff <= !oq_rd_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (oq_push) oq_ff[oq_wr_ff] <= entry;
   end

   a_ok_has_mode: assert property (@(posedge clock) disable iff (reset)
      (oq_push && decode_ok) |-> (mode != MODE_INVALID))
      else $error("good packet decoded without a mode");

   a_ok_exp_range: assert property (@(posedge clock) disable iff (reset)
      (oq_push && decode_ok) |-> (ex.value >= -5'sd12 && ex.value <= 5'sd4))
      else $error("decoded exponent out of range");

   a_oq_cnt: assert property (@(posedge clock) disable iff (reset)
      oq_cnt_ff != 2'd3)
      else $error("result queue count out of range");

endmodule

>>> src/dmm_serial_packet_decoder_top.sv
// Path: words -> packet queue -> decode -> result queue -> rsp_ ports.
// Throughput: one word per cycle while full is low; one packet decode per
//   cycle in the back end while the result queue has room.
// Reset: synchronous, active high; clears the byte position, both queues and
//   the held reading (all kinds and the mode read as invalid, flags clear).
module dmm_serial_packet_decoder_top (
   input  logic               clock,
   input  logic               reset,
   // byte words in
   input  logic               push,
   output logic               full,
   input  logic [7:0]         req_rx_byte,
   input  logic               req_last_byte,
   // decoded results out
   output logic               empty,
   input  logic               pop,
   output logic               rsp_packet_ok,
   output logic signed [17:0] rsp_mantissa,
   output logic signed [4:0]  rsp_exponent,
   output logic [3:0]         rsp_mode,
   output logic [1:0]         rsp_power_kind,
   output logic [1:0]         rsp_range_error,
   output logic [1:0]         rsp_peak_kind,
   output logic               rsp_battery_low,
   output logic               rsp_relative_on,
   output logic               rsp_hold_on,
   output logic               rsp_auto_range
);
   import spd_pkg::*;

   // Front end collects bytes; the packet that closes on a marked word is
   // handed to a two-entry packet queue so the decoder can stall alone.
   logic        fq_push, fq_full, fq_empty, fq_pop;
   packet_type  fq_wr_pkt, fq_rd_pkt;
   result_type  rsp;

   spd_front u_front (
      .clock         (clock),
      .reset         (reset),
      .push          (push),
      .full          (full),
      .req_rx_byte   (req_rx_byte),
      .req_last_byte (req_last_byte),
      .fifo_full     (fq_full),
      .fifo_push     (fq_push),
      .fifo_pkt      (fq_wr_pkt)
   );

   spd_pkt_fifo u_pkt_fifo (
      .clock    (clock),
      .reset    (reset),
      .wr_push  (fq_push),
      .wr_pkt   (fq_wr_pkt),
      .wr_full  (fq_full),
      .rd_pop   (fq_pop),
      .rd_pkt   (fq_rd_pkt),
      .rd_empty (fq_empty)
   );

   // Back end: header, trailer, digit and range checks, mode priority,
   // held reading update, then a two-entry result queue.
   spd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pkt       (fq_rd_pkt),
      .pkt_empty (fq_empty),
      .pkt_pop   (fq_pop),
      .empty     (empty),
      .pop       (pop),
      .rsp       (rsp)
   );

   assign rsp_packet_ok   = rsp.packet_ok;
   assign rsp_mantissa    = rsp.mantissa;
   assign rsp_exponent    = rsp.exponent;
   assign rsp_mode        = rsp.mode;
   assign rsp_power_kind  = rsp.power_kind;
   assign rsp_range_error = rsp.range_error;
   assign rsp_peak_kind   = rsp.peak_kind;
   assign rsp_battery_low = rsp.battery_low;
   assign rsp_relative_on = rsp.relative_on;
   assign rsp_hold_on     = rsp.hold_on;
   assign rsp_auto_range  = rsp.auto_range;

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 100ps

module tb;
   import spd_pkg::*;

   // Watchdog. The slowest correct run is about 1600 words, each behind the longest
   // send gap, plus at most one reading per word, each behind the longest receive
   // stall; CYCLE_LIMIT leaves plenty of margin over that.
   localparam int CYCLE_LIMIT = 400000;
   localparam int RANDOM_WORDS = 1320;
   localparam int CALM_TAIL = 300;        // the last words of the run are sent with no idling

   // -----------------------------------------------------------------------
   // Scoreboard: tracks the packet being assembled and the held reading,
   // predicts one reading per marked byte, and checks readings in order.
   // -----------------------------------------------------------------------
   class reading_scoreboard;
      logic [7:0]  pkt_store[PKT_LEN];
      int unsigned byte_pos;
      result_type  held;
      result_type  expected_readings[$];
      int unsigned error_count;

      function new();
         byte_pos    = 0;
         held        = '0;
         error_count = 0;
      endfunction

      function void report(string msg);
         error_count++;
         if (error_count <= 10) $display("%t mismatch: %s", $realtime, msg);
      endfunction

      function bit range_exponent(exp_tab_type tab, logic [7:0] code, output int ex);
         int t[8];
         int n;
         int idx;
         ex = 0;
         if (tab == TAB_NONE) return 1'b1;
         case (tab)
            TAB_DUTY:  begin n = 1; t = '{-1, 0, 0, 0, 0, 0, 0, 0}; end
            TAB_HZ:    begin n = 8; t = '{-2, -1, 0, 0, 1, 2, 3, 4}; end
            TAB_AMP0:  begin n = 1; t = '{-3, 0, 0, 0, 0, 0, 0, 0}; end
            TAB_OHM:   begin n = 7; t = '{-2, -1, 0, 1, 2, 3, 4, 0}; end
            TAB_FARAD: begin n = 8; t = '{-12, -11, -10, -9, -8, -7, -6, -5}; end
            TAB_VOLT:  begin n = 5; t = '{-4, -3, -2, -1, -5, 0, 0, 0}; end
            TAB_UA:    begin n = 2; t = '{-8, -7, 0, 0, 0, 0, 0, 0}; end
            default:   begin n = 2; t = '{-6, -5, 0, 0, 0, 0, 0, 0}; end
         endcase
         if (code < ASCII_ZERO) return 1'b0;
         idx = int'(code) - int'(ASCII_ZERO);
         if (idx >= n) return 1'b0;
         if (tab == TAB_HZ && idx == 2) return 1'b0;   // frequency table has a hole
         ex = t[idx];
         return 1'b1;
      endfunction

      // Decode the fourteen stored bytes; on success replace the held reading.
      function bit decode_meter_packet();
         int          val;
         int          ex;
         logic [7:0]  c;
         logic [3:0]  md;
         exp_tab_type tab;
         result_type  r;
         val = 0;
         if (pkt_store[0][5:4] != 2'b11 || pkt_store[12] != CHAR_CR ||
             pkt_store[13] != CHAR_LF) return 1'b0;
         for (int i = 1; i <= 5; i++) begin
            c = pkt_store[i];
            if (c < ASCII_ZERO || c > ASCII_NINE) return 1'b0;
            val = val * 10 + (int'(c) - int'(ASCII_ZERO));
         end
         if (pkt_store[7][2]) val = -val;

         if (pkt_store[7][3]) begin
            md = MODE_DUTY;  tab = TAB_DUTY;
         end else if (pkt_store[10][0]) begin
            md = MODE_HZ;    tab = TAB_HZ;
         end else begin
            case (pkt_store[6])
               FN_AMP0:  begin md = MODE_AMP;   tab = TAB_AMP0;  end
               FN_DIODE: begin md = MODE_DIODE; tab = TAB_NONE;  end
               FN_HZ:    begin md = MODE_HZ;    tab = TAB_HZ;    end
               FN_OHM:   begin md = MODE_OHM;   tab = TAB_OHM;   end
               FN_COND:  begin md = MODE_COND;  tab = TAB_NONE;  end
               FN_FARAD: begin md = MODE_FARAD; tab = TAB_FARAD; end
               FN_VOLT:  begin md = MODE_VOLT;  tab = TAB_VOLT;  end
               FN_UA:    begin md = MODE_AMP;   tab = TAB_UA;    end
               FN_MA:    begin md = MODE_AMP;   tab = TAB_MA;    end
               default:  return 1'b0;
            endcase
         end
         if (!range_exponent(tab, pkt_store[0], ex)) return 1'b0;

         r = '0;
         r.mantissa    = val[17:0];
         r.exponent    = ex[4:0];
         r.mode        = md;
         r.power_kind  = pkt_store[10][3] ? POWER_DC :
                         pkt_store[10][2] ? POWER_AC : POWER_NONE;
         r.range_error = pkt_store[7][0] ? ERR_OVER :
                         pkt_store[9][3] ? ERR_UNDER : ERR_NONE;
         r.peak_kind   = pkt_store[9][2] ? PEAK_MAX :
                         pkt_store[9][1] ? PEAK_MIN : PEAK_NONE;
         r.battery_low = pkt_store[7][1];
         r.relative_on = pkt_store[8][1];
         r.hold_on     = pkt_store[11][1];
         r.auto_range  = pkt_store[10][1];
         held = r;
         return 1'b1;
      endfunction

      function void note_word(logic [7:0] b, logic last);
         result_type r;
         bit         ok;
         if (byte_pos < PKT_LEN) begin
            pkt_store[byte_pos] = b;
            byte_pos++;
         end
         if (!last) return;
         ok = 1'b0;
         if (byte_pos >= PKT_LEN) ok = decode_meter_packet();
         byte_pos = 0;
         r = held;
         r.packet_ok = ok;
         expected_readings.push_back(r);
      endfunction

      function string show(result_type r);
         return $sformatf("ok %0b man %0d exp %0d mode %0d pw %0d err %0d pk %0d flags %b%b%b%b",
                          r.packet_ok, r.mantissa, r.exponent, r.mode, r.power_kind,
                          r.range_error, r.peak_kind, r.battery_low, r.relative_on,
                          r.hold_on, r.auto_range);
      endfunction

      function void check_reading(result_type got);
         result_type want;
         if (expected_readings.size() == 0) begin
            report({"unexpected reading: ", show(got)});
            return;
         end
         want = expected_readings.pop_front();
         if (got.packet_ok   !== want.packet_ok   || got.mantissa    !== want.mantissa   ||
             got.exponent    !== want.exponent    || got.mode        !== want.mode       ||
             got.power_kind  !== want.power_kind  || got.range_error !== want.range_error ||
             got.peak_kind   !== want.peak_kind   || got.battery_low !== want.battery_low ||
             got.relative_on !== want.relative_on || got.hold_on     !== want.hold_on    ||
             got.auto_range  !== want.auto_range)
            report({"expected ", show(want), " got ", show(got)});
      endfunction
   endclass

   // -----------------------------------------------------------------------
   // DUT and its wiring
   // -----------------------------------------------------------------------
   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               push = 1'b0;
   logic               full;
   logic [7:0]         req_rx_byte = '0;
   logic               req_last_byte = 1'b0;
   logic               empty;
   logic               pop = 1'b0;
   logic               rsp_packet_ok;
   logic signed [17:0] rsp_mantissa;
   logic signed [4:0]  rsp_exponent;
   logic [3:0]         rsp_mode;
   logic [1:0]         rsp_power_kind;
   logic [1:0]         rsp_range_error;
   logic [1:0]         rsp_peak_kind;
   logic               rsp_battery_low;
   logic               rsp_relative_on;
   logic               rsp_hold_on;
   logic               rsp_auto_range;

   dmm_serial_packet_decoder_top DUT (
      .clock, .reset, .push, .full, .req_rx_byte, .req_last_byte,
      .empty, .pop, .rsp_packet_ok, .rsp_mantissa, .rsp_exponent, .rsp_mode,
      .rsp_power_kind, .rsp_range_error, .rsp_peak_kind, .rsp_battery_low,
      .rsp_relative_on, .rsp_hold_on, .rsp_auto_range
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   reading_scoreboard board = new();
   int unsigned       cycle_count = 0;
   int unsigned       words_sent = 0;
   int                send_idle_pct = 0;   // chance of a send gap before a word
   int                recv_idle_pct = 0;   // chance of a receive stall per cycle
   int                stall_left = 0;
   logic [7:0]        pkt_q[$];            // packet being built for sending

   // Function bytes in the order the random generator picks them, then the
   // duty-flag and frequency-flag packets. Span 0 means any range code that
   // passes the header check is accepted (diode, conductance).
   localparam logic [7:0] FN_PICK[9] = '{FN_AMP0, FN_DIODE, FN_HZ, FN_OHM, FN_COND,
                                         FN_FARAD, FN_VOLT, FN_UA, FN_MA};
   localparam int RANGE_SPAN[11] = '{1, 0, 8, 7, 0, 8, 5, 2, 2, 1, 8};
   localparam int SEL_HZ   = 2;
   localparam int SEL_DUTY = 9;
   localparam int SEL_FREQ = 10;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // -----------------------------------------------------------------------
   // Reading side: check the word popped at this edge, then pick the next
   // pop, or start a burst of stalls.
   // -----------------------------------------------------------------------
   function automatic result_type sample_reading();
      result_type r;
      r.packet_ok   = rsp_packet_ok;
      r.mantissa    = rsp_mantissa;
      r.exponent    = rsp_exponent;
      r.mode        = rsp_mode;
      r.power_kind  = rsp_power_kind;
      r.range_error = rsp_range_error;
      r.peak_kind   = rsp_peak_kind;
      r.battery_low = rsp_battery_low;
      r.relative_on = rsp_relative_on;
      r.hold_on     = rsp_hold_on;
      r.auto_range  = rsp_auto_range;
      return r;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         pop <= 1'b0;
         stall_left = 0;
      end else begin
         if (pop && !empty) board.check_reading(sample_reading());
         if (stall_left > 0) begin
            stall_left--;
            pop <= 1'b0;
         end else if (recv_idle_pct != 0 && $urandom_range(0, 99) < recv_idle_pct) begin
            stall_left = $urandom_range(1, 13) - 1;
            pop <= 1'b0;
         end else begin
            pop <= 1'b1;
         end
      end
   end

   // -----------------------------------------------------------------------
   // Byte side
   // -----------------------------------------------------------------------
   // push stays high from one word to the next unless a gap is taken, so it
   // never gets two assignments in one time step.
   task automatic send_word(logic [7:0] b, logic last);
      if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
         push <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
      req_rx_byte   <= b;
      req_last_byte <= last;
      push          <= 1'b1;
      do @(posedge clock); while (full);
      board.note_word(b, last);
      words_sent++;
   endtask

   task automatic send_packet();
      foreach (pkt_q[i]) send_word(pkt_q[i], i == pkt_q.size() - 1);
   endtask

   // Builds a 14-byte packet with the given range code, digits, function
   // byte and status bytes 7..11, ending in CR LF.
   function automatic void form_packet(logic [7:0] range_code, int digits, logic [7:0] fn,
                                       logic [7:0] b7, logic [7:0] b8, logic [7:0] b9,
                                       logic [7:0] b10, logic [7:0] b11);
      logic [7:0] chars[5];
      int         d;
      d = digits;
      for (int i = 4; i >= 0; i--) begin
         chars[i] = ASCII_ZERO + 8'(d % 10);
         d = d / 10;
      end
      pkt_q = {range_code, chars[0], chars[1], chars[2], chars[3], chars[4], fn,
               b7, b8, b9, b10, b11, CHAR_CR, CHAR_LF};
   endfunction

   // Well-formed packet with random content; a small share of range codes
   // are random and will mostly fail the table lookup.
   function automatic void form_random_packet();
      int         sel;
      int         idx;
      int         digits;
      logic [7:0] fn;
      logic [7:0] code;
      logic [7:0] b7;
      logic [7:0] b10;
      sel = $urandom_range(0, 10);
      fn  = (sel < 9) ? FN_PICK[sel] : 8'($urandom_range(0, 255));
      b7  = 8'($urandom_range(0, 255));
      b10 = 8'($urandom_range(0, 255));
      // duty flag wins over frequency flag, which wins over the function byte
      b7[3]  = (sel == SEL_DUTY);
      b10[0] = (sel == SEL_FREQ) ? 1'b1 : (sel == SEL_DUTY) ? b10[0] : 1'b0;
      if (RANGE_SPAN[sel] == 0) begin
         code = 8'($urandom_range(0, 255)) | 8'h30;
      end else begin
         idx = $urandom_range(0, RANGE_SPAN[sel] - 1);
         if ((sel == SEL_HZ || sel == SEL_FREQ) && idx == 2) idx = 3;
         code = ASCII_ZERO + 8'(idx);
      end
      if ($urandom_range(0, 9) == 0) code = 8'($urandom_range(0, 255));
      case ($urandom_range(0, 9))
         0:       digits = 0;
         1:       digits = 99999;
         default: digits = $urandom_range(0, 99999);
      endcase
      form_packet(code, digits, fn, b7, 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)), b10, 8'($urandom_range(0, 255)));
   endfunction

   // -----------------------------------------------------------------------
   // Main sequence
   // -----------------------------------------------------------------------
   initial begin
      int kind;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // --- directed packets ---
      // lone marked byte straight after reset: short packet, held reading invalid
      send_word(8'h30, 1'b1);
      // volts, largest mantissa, first range
      form_packet(ASCII_ZERO, 99999, FN_VOLT, 8'h30, 8'h30, 8'h30, 8'h30, 8'h30);
      send_packet();
      // negative full scale, every flag, underload, DC over AC, 1e-5 range
      form_packet(ASCII_ZERO + 8'd4, 99999, FN_VOLT, 8'h36, 8'h32, 8'h38, 8'h3E, 8'h32);
      send_packet();
      // negative zero, ohms top range (exponent 4)
      form_packet(ASCII_ZERO + 8'd6, 0, FN_OHM, 8'h34, 8'h30, 8'h30, 8'h30, 8'h30);
      send_packet();
      // farads lowest range (exponent -12), overload beats underload, max
      form_packet(ASCII_ZERO, 12345, FN_FARAD, 8'h31, 8'h30, 8'h3C, 8'h30, 8'h30);
      send_packet();
      // frequency function byte, highest range, minimum, AC
      form_packet(ASCII_ZERO + 8'd7, 54321, FN_HZ, 8'h30, 8'h30, 8'h32, 8'h34, 8'h30);
      send_packet();
      // frequency table hole: rejected
      form_packet(ASCII_ZERO + 8'd2, 11111, FN_HZ, 8'h30, 8'h30, 8'h30, 8'h30, 8'h30);
      send_packet();
      // duty flag over frequency flag over function byte
      form_packet(ASCII_ZERO, 500, FN_VOLT, 8'h38, 8'h30, 8'h30, 8'h31, 8'h30);
      send_packet();
      // frequency flag over an ohms function byte
      form_packet(ASCII_ZERO + 8'd3, 777, FN_OHM, 8'h30, 8'h30, 8'h30, 8'h31, 8'h30);
      send_packet();
      form_packet(ASCII_ZERO, 1, FN_AMP0, 8'h30, 8'h30, 8'h30, 8'h30, 8'h30);
      send_packet();
      form_packet(ASCII_ZERO + 8'd1, 2, FN_UA, 8'h30, 8'h30, 8'h30, 8'h30, 8'h30);
      send_packet();
      form_packet(ASCII_ZERO, 3, FN_MA, 8'h30, 8'h30, 8'h30, 8'h30, 8'h30);
      send_packet();
      // diode and conductance take any range code that passes the header
      form_packet(8'hFF, 4, FN_DIODE, 8'h30, 8'h30, 8'h30, 8'h30, 8'h30);
      send_packet();
      form_packet(8'h3F, 5, FN_COND, 8'h30, 8'h30, 8'h30, 8'h30, 8'h30);
      send_packet();
      // header fails on a diode packet
      form_packet(8'h20, 6, FN_DIODE, 8'h30, 8'h30, 8'h30, 8'h30, 8'h30);
      send_packet();
      // unknown function byte
      form_packet(ASCII_ZERO, 7, 8'h34, 8'h30, 8'h30, 8'h30, 8'h30, 8'h30);
      send_packet();
      // volts range past the table
      form_packet(ASCII_ZERO + 8'd5, 8, FN_VOLT, 8'h30, 8'h30, 8'h30, 8'h30, 8'h30);
      send_packet();
      // trailer swapped
      form_packet(ASCII_ZERO, 9, FN_VOLT, 8'h30, 8'h30, 8'h30, 8'h30, 8'h30);
      pkt_q[12] = CHAR_LF;
      pkt_q[13] = CHAR_CR;
      send_packet();
      // digits just outside '0'..'9' on both sides
      form_packet(ASCII_ZERO, 10, FN_VOLT, 8'h30, 8'h30, 8'h30, 8'h30, 8'h30);
      pkt_q[3] = ASCII_NINE + 8'd1;
      send_packet();
      form_packet(ASCII_ZERO, 10, FN_VOLT, 8'h30, 8'h30, 8'h30, 8'h30, 8'h30);
      pkt_q[5] = ASCII_ZERO - 8'd1;
      send_packet();
      // long packet: the bytes past the fourteenth are dropped
      form_packet(ASCII_ZERO + 8'd2, 424, FN_OHM, 8'h30, 8'h30, 8'h30, 8'h30, 8'h30);
      pkt_q.push_back(8'h00);
      pkt_q.push_back(8'hFF);
      send_packet();
      // short packet: thirteen bytes
      form_packet(ASCII_ZERO, 99, FN_VOLT, 8'h30, 8'h30, 8'h30, 8'h30, 8'h30);
      void'(pkt_q.pop_back());
      send_packet();

      // --- random packets ---
      words_sent = 0;
      while (words_sent < RANDOM_WORDS) begin
         // idling level changes per packet, with calm stretches, none at the tail
         if (words_sent + CALM_TAIL >= RANDOM_WORDS) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end else begin
            case ($urandom_range(0, 3))
               0, 1:    send_idle_pct = 0;
               2:       send_idle_pct = 15;
               default: send_idle_pct = 50;
            endcase
            case ($urandom_range(0, 3))
               0, 1:    recv_idle_pct = 0;
               2:       recv_idle_pct = 15;
               default: recv_idle_pct = 60;
            endcase
         end
         kind = $urandom_range(0, 99);
         if (kind < 96) begin
            form_random_packet();
            if (kind >= 72 && kind < 82) begin
               pkt_q[$urandom_range(0, PKT_LEN - 1)] = 8'($urandom_range(0, 255));
            end else if (kind >= 82 && kind < 90) begin
               pkt_q = pkt_q[0:$urandom_range(0, PKT_LEN - 2)];
            end else if (kind >= 90) begin
               repeat ($urandom_range(1, 6)) pkt_q.push_back(8'($urandom_range(0, 255)));
            end
            send_packet();
         end else begin
            // noise: random bytes with random marks, closed by a marked byte
            repeat ($urandom_range(0, 19)) send_word(8'($urandom_range(0, 255)),
                                                     $urandom_range(0, 7) == 0);
            send_word(8'($urandom_range(0, 255)), 1'b1);
         end
      end
      push <= 1'b0;

      // drain, then run on so that stray readings from the decode queues still get checked
      while (board.expected_readings.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (board.error_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

>>> sim.f
src/spd_pkg.sv
src/spd_front.sv
src/spd_pkt_fifo.sv
src/spd_back.sv
src/dmm_serial_packet_decoder_top.sv
tb/sv/tb.sv
